/* sv/pdq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdq_pkg: shared types and codes of the process deque
// Entry layout, operation codes and the control word of a deque cell.
// ----------------------------------------------------------------------------
package pdq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int OP_W      = 4;
	localparam int PID_W     = 16;
	localparam int STOP_W    = 32;
	localparam int OCC_W     = 5;

	localparam logic [OP_W-1:0] OP_PUSHF   = 4'd0;
	localparam logic [OP_W-1:0] OP_PUSHB   = 4'd1;
	localparam logic [OP_W-1:0] OP_POPF    = 4'd2;
	localparam logic [OP_W-1:0] OP_POPB    = 4'd3;
	localparam logic [OP_W-1:0] OP_PEEKF   = 4'd4;
	localparam logic [OP_W-1:0] OP_PEEKB   = 4'd5;
	localparam logic [OP_W-1:0] OP_FIND    = 4'd6;
	localparam logic [OP_W-1:0] OP_DELETE  = 4'd7;
	localparam logic [OP_W-1:0] OP_MAXSTOP = 4'd8;
	localparam logic [OP_W-1:0] OP_LASTBG  = 4'd9;

	typedef struct packed {
		logic [PID_W-1:0]  pid;
		logic [STOP_W-1:0] stop;
		logic              bg;
	} entry_t;

	typedef enum logic [2:0] {
		CM_HOLD  = 3'd0,
		CM_SHR   = 3'd1,
		CM_ROT   = 3'd2,
		CM_CLOSE = 3'd3,
		CM_PUT   = 3'd4
	} cell_mode_t;

	typedef struct packed {
		cell_mode_t mode;
		entry_t     ent;
	} cell_ctl_t;

endpackage

/* sv/pdq_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdq_cell: one slot of the deque
// Holds one entry and loads it from its left or right neighbor, from the new
// entry, or keeps it, as the broadcast control word and its own index decide.
// ----------------------------------------------------------------------------
module pdq_cell #(
	parameter int IW  = 4,
	parameter int IDX = 0
) (
	input  logic               clk,
	input  pdq_pkg::cell_ctl_t ctl,
	input  logic [IW-1:0]      idx,
	input  pdq_pkg::entry_t    left,
	input  pdq_pkg::entry_t    right,
	output pdq_pkg::entry_t    ent_q
);

	localparam logic [IW-1:0] MY_IDX = IW'(IDX);

	always_ff @(posedge clk) begin
		case (ctl.mode)
			pdq_pkg::CM_SHR: begin
				ent_q <= (IDX == 0) ? ctl.ent : left;
			end
			pdq_pkg::CM_ROT: begin
				ent_q <= right;
			end
			pdq_pkg::CM_CLOSE: begin
				if (MY_IDX >= idx) begin
					ent_q <= right;
				end
			end
			pdq_pkg::CM_PUT: begin
				if (MY_IDX == idx) begin
					ent_q <= ctl.ent;
				end
			end
			default: begin
				ent_q <= ent_q;
			end
		endcase
	end

endmodule

/* sv/process_deque_with_search.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// process_deque_with_search: deque of process entries with search and delete
// A ring of DEPTH cells holds the entries front to back; searches rotate the
// ring once past a scanner at the front cell.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid, in_stall) carries one operation beat
// with op, pid_in, stop_time_in and background_in. The output channel
// (out_valid, out_stall) returns one beat per operation with ok, the entry
// and the occupancy after the operation.
// Pushes, pop front, peek front and undefined codes go from IDLE straight to
// DONE. Peek back, pop back, find, delete, maxstop and lastbg rotate the
// whole ring once through the front cell in SCAN, and a removal passes
// through CLOSE to close the gap before DONE. One operation is in work at a
// time: a new one is accepted only once the result has left DONE.
// A finished result waits in the output register while out_stall is high;
// the next operation is accepted meanwhile and its result is held until the
// register frees up.
// Reset empties the deque; slot contents are not cleared and are never read
// before being written.
// ----------------------------------------------------------------------------
module process_deque_with_search #(
	parameter int DEPTH = pdq_pkg::DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [pdq_pkg::OP_W-1:0]    op,
	input  logic [pdq_pkg::PID_W-1:0]   pid_in,
	input  logic [pdq_pkg::STOP_W-1:0]  stop_time_in,
	input  logic                        background_in,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        ok,
	output logic [pdq_pkg::PID_W-1:0]   pid_out,
	output logic [pdq_pkg::STOP_W-1:0]  stop_time_out,
	output logic                        background_out,
	output logic [pdq_pkg::OCC_W-1:0]   occupancy
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
	localparam logic [IW-1:0] LAST_J   = IW'(DEPTH - 1);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCAN  = 4'b0010,
		S_CLOSE = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	state_t                       state_q, state_n;
	logic [CW-1:0]                count_q, count_n;
	logic [IW-1:0]                j_q, j_n;
	logic [IW-1:0]                idx_q, idx_n;
	logic                         res_ok_q, res_ok_n;
	pdq_pkg::entry_t              res_ent_q, res_ent_n;
	logic [pdq_pkg::OP_W-1:0]     op_q;
	logic [pdq_pkg::PID_W-1:0]    key_q;
	logic                         out_valid_q;
	logic                         out_load;
	logic                         in_acc;
	logic                         full, empty;
	logic                         in_range, take;
	logic [CW-1:0]                j_ext;
	pdq_pkg::entry_t              new_ent;
	pdq_pkg::entry_t              cand;
	pdq_pkg::cell_ctl_t           ctl;
	logic [IW-1:0]                cidx;
	pdq_pkg::entry_t              cell_q [DEPTH];

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign full      = (count_q == FULL_CNT);
	assign empty     = (count_q == '0);
	assign new_ent   = '{pid: pid_in, stop: stop_time_in, bg: background_in};
	assign cand      = cell_q[0];
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;

	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		pdq_cell #(
			.IW  (IW),
			.IDX (k)
		) u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.idx   (cidx),
			.left  ((k == 0) ? new_ent : cell_q[(k + DEPTH - 1) % DEPTH]),
			.right (cell_q[(k + 1) % DEPTH]),
			.ent_q (cell_q[k])
		);
	end

	always_comb begin
		ctl.mode = pdq_pkg::CM_HOLD;
		ctl.ent  = new_ent;
		cidx     = idx_q;
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					case (op)
						pdq_pkg::OP_PUSHF: begin
							if (!full) begin
								ctl.mode = pdq_pkg::CM_SHR;
							end
						end
						pdq_pkg::OP_PUSHB: begin
							if (!full) begin
								ctl.mode = pdq_pkg::CM_PUT;
								cidx     = count_q[IW-1:0];
							end
						end
						pdq_pkg::OP_POPF: begin
							if (!empty) begin
								ctl.mode = pdq_pkg::CM_CLOSE;
								cidx     = '0;
							end
						end
						default: begin
							ctl.mode = pdq_pkg::CM_HOLD;
						end
					endcase
				end
			end
			S_SCAN:  ctl.mode = pdq_pkg::CM_ROT;
			S_CLOSE: ctl.mode = pdq_pkg::CM_CLOSE;
			default: ctl.mode = pdq_pkg::CM_HOLD;
		endcase
	end

	always_comb begin
		j_ext    = CW'(j_q);
		in_range = (j_ext < count_q);
		case (op_q)
			pdq_pkg::OP_PEEKB, pdq_pkg::OP_POPB: begin
				take = in_range && ((j_ext + CW'(1)) == count_q);
			end
			pdq_pkg::OP_FIND, pdq_pkg::OP_DELETE: begin
				take = in_range && !res_ok_q && (cand.pid == key_q);
			end
			pdq_pkg::OP_MAXSTOP: begin
				take = in_range && (cand.stop > res_ent_q.stop);
			end
			pdq_pkg::OP_LASTBG: begin
				take = in_range && cand.bg;
			end
			default: begin
				take = 1'b0;
			end
		endcase
	end

	always_comb begin
		state_n   = state_q;
		count_n   = count_q;
		j_n       = j_q;
		idx_n     = idx_q;
		res_ok_n  = res_ok_q;
		res_ent_n = res_ent_q;
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					j_n       = '0;
					res_ok_n  = 1'b0;
					res_ent_n = '0;
					state_n   = S_DONE;
					case (op)
						pdq_pkg::OP_PUSHF, pdq_pkg::OP_PUSHB: begin
							if (!full) begin
								count_n   = count_q + CW'(1);
								res_ok_n  = 1'b1;
								res_ent_n = new_ent;
							end
						end
						pdq_pkg::OP_POPF, pdq_pkg::OP_PEEKF: begin
							if (!empty) begin
								res_ok_n  = 1'b1;
								res_ent_n = cand;
								if (op == pdq_pkg::OP_POPF) begin
									count_n = count_q - CW'(1);
								end
							end
						end
						pdq_pkg::OP_PEEKB, pdq_pkg::OP_POPB, pdq_pkg::OP_FIND,
						pdq_pkg::OP_DELETE, pdq_pkg::OP_MAXSTOP, pdq_pkg::OP_LASTBG: begin
							state_n = S_SCAN;
						end
						default: begin
							state_n = S_DONE;
						end
					endcase
				end
			end
			S_SCAN: begin
				if (take) begin
					res_ok_n  = 1'b1;
					res_ent_n = cand;
					idx_n     = j_q;
				end
				j_n = j_q + IW'(1);
				if (j_q == LAST_J) begin
					if (res_ok_n && ((op_q == pdq_pkg::OP_POPB) ||
							(op_q == pdq_pkg::OP_DELETE))) begin
						state_n = S_CLOSE;
					end else begin
						state_n = S_DONE;
					end
				end
			end
			S_CLOSE: begin
				count_n = count_q - CW'(1);
				state_n = S_DONE;
			end
			S_DONE: begin
				if (out_load) begin
					state_n = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			j_q         <= '0;
			res_ok_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_n;
			count_q  <= count_n;
			j_q      <= j_n;
			res_ok_q <= res_ok_n;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q     <= idx_n;
		res_ent_q <= res_ent_n;
		if (in_acc) begin
			op_q  <= op;
			key_q <= pid_in;
		end
		if (out_load) begin
			ok             <= res_ok_q;
			pid_out        <= res_ent_q.pid;
			stop_time_out  <= res_ent_q.stop;
			background_out <= res_ent_q.bg;
			occupancy      <= pdq_pkg::OCC_W'(count_q);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("entry count above depth");

	a_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && j_q == LAST_J) |=> (state_q == S_CLOSE || state_q == S_DONE))
		else $error("scan did not end after one full rotation");

	a_close_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLOSE) |=> (count_q == $past(count_q) - CW'(1)))
		else $error("removal did not decrement the count");

	a_full_push: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && full && (op == pdq_pkg::OP_PUSHF || op == pdq_pkg::OP_PUSHB))
		|=> (!res_ok_q && $stable(count_q)))
		else $error("push into a full deque was not refused");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && !res_ok_q) |-> (res_ent_q == '0))
		else $error("failed operation carries a nonzero entry");

endmodule
